/* rtl/polygon_normal_area_setup_unit_macros.svh */
// Assertion macros for the polygon normal and area setup unit.
// Used by the checker; every macro samples on clk_i and is disabled in reset.
`ifndef POLYGON_NORMAL_AREA_SETUP_UNIT_MACROS_SVH
`define POLYGON_NORMAL_AREA_SETUP_UNIT_MACROS_SVH

// Plain property, sampled on the rising clock edge outside reset
`define PNAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define PNAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PNAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pnas_pkg.sv */
// Package for the polygon normal and area setup unit.
// Holds payload structs, status codes, axis codes and sequencer states; no dependencies.
`timescale 1ns / 1ps

package pnas_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_DEGENERATE = 2'd1,
    STATUS_OVERFLOW   = 2'd2
  } pnas_status_e;

  // Axis indexes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_TERM,
    S_SQ,
    S_SQRT,
    S_NDIV,
    S_TRI,
    S_DELTA,
    S_CDIV,
    S_DONE
  } pnas_state_e;

  // One input item: a vertex
  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_z;
    logic               last_vertex;
  } pnas_in_t;

  // One result item
  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [40:0]        area;
    logic [1:0]         axis_u;
    logic [1:0]         axis_v;
    logic signed [31:0] coef_x1;
    logic signed [31:0] coef_y1;
    logic signed [31:0] coef_x2;
    logic signed [31:0] coef_y2;
    logic [1:0]         status;
  } pnas_out_t;

endpackage

/* rtl/pnas_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the top level for normal and coefficient divisions.
`timescale 1ns / 1ps

module pnas_div #(
  parameter int DW = 57,
  parameter int NW = 41
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [NW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] dvd_q;
  logic [DW-1:0] quo_q;
  logic [NW-1:0] rem_q;
  logic [NW-1:0] den_q;
  logic [NW:0]   rem_sh;
  logic          fits;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh = {rem_q, dvd_q[DW-1]};
    fits   = rem_sh >= {1'b0, den_q};
  end

  // Control: run DW steps, pulse done after the last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CW'(DW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      quo_q <= {quo_q[DW-2:0], fits};
      rem_q <= fits ? NW'(rem_sh - {1'b0, den_q}) : rem_sh[NW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/polygon_normal_area_setup_unit.sv */
// Polygon normal, area and triangle setup: top level with sequencer and datapath.
// Depends on pnas_pkg and pnas_div.
`timescale 1ns / 1ps

// Usage
//   Input channel in_valid_i / in_stall_o / in_data_i carries one vertex per
//   item; the item with last_vertex set closes the polygon and causes one
//   result on out_valid_o / out_stall_i / out_data_o. Other items cause none.
//   A vertex that adds an edge stalls the input while one 17x17 multiplier
//   forms three Newell products, with one add each; the first vertex and
//   vertices past MAX_VERTICES are taken without a stall. After the last
//   vertex come its edge terms, the bit-serial squares of the AW-bit
//   sums (AW = 35 + clog2(MAX_VERTICES)), the square root, the normal
//   divisions and, for a triangle, the coefficient divisions, all on one
//   shared restoring divider of DW = AW + 16 bits, and then the load of
//   the output register.
//   Reset clears the polygon state and the result valid flag; no item is
//   pending afterwards. A stalled result holds in the output register; the
//   next polygon may be accepted meanwhile, but its result waits until the
//   earlier one has been taken.
module polygon_normal_area_setup_unit #(
  parameter int MAX_VERTICES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pnas_pkg::pnas_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pnas_pkg::pnas_out_t out_data_o
);

  localparam int AW   = 35 + $clog2(MAX_VERTICES);
  localparam int SW   = 2 * AW;
  localparam int DW   = AW + 16;
  localparam int CW   = $clog2(DW + 2);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);

  pnas_pkg::pnas_state_e state_q, state_d;

  logic [CW-1:0]   cnt_q;
  logic [1:0]      k_q;
  logic            started_q;
  logic            closing_q;
  logic            last_q;

  logic signed [15:0] first_q [3];
  logic signed [15:0] second_q [3];
  logic signed [15:0] prev_q [3];
  logic signed [15:0] v_q [3];
  logic signed [15:0] ta_q [3];
  logic signed [15:0] tb_q [3];
  logic signed [15:0] vin [3];

  logic [CNTW-1:0]    count_q;
  logic               ovf_q;
  logic signed [AW-1:0] acc_q [3];
  logic [AW-1:0]      mag [3];

  logic signed [33:0] prod_q;
  logic signed [33:0] prod;
  logic signed [16:0] mul_a, mul_b;
  logic signed [16:0] t_diff, t_sum;

  logic [SW-1:0]   mcand_q;
  logic [AW-1:0]   mplier_q;
  logic [SW-1:0]   sum_q;
  logic [AW+1:0]   rem_q;
  logic [AW-1:0]   root_q;
  logic [AW+3:0]   rem_sh, trial;
  logic            sq_ge;

  logic signed [15:0] nrm_q [3];
  logic [40:0]        area_q;
  logic [1:0]         au_q, av_q;
  logic [1:0]         au_c, av_c;
  logic signed [31:0] coef_q [4];
  logic signed [16:0] cx_q [4];
  logic signed [34:0] delta_q;
  logic [34:0]        delta_mag;
  pnas_pkg::pnas_status_e status_q;

  logic            out_valid_q;
  pnas_pkg::pnas_out_t out_q;

  logic            in_acc;
  logic            out_free;
  logic            div_start;
  logic            div_done;
  logic [DW-1:0]   div_dvd;
  logic [AW-1:0]   div_den;
  logic [DW-1:0]   div_quo;
  logic            div_neg;
  logic [16:0]     cx_mag;
  logic signed [15:0] sat16;
  logic signed [31:0] sat32;
  logic            room;

  assign vin[0] = in_data_i.vertex_x;
  assign vin[1] = in_data_i.vertex_y;
  assign vin[2] = in_data_i.vertex_z;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign room     = count_q < CNTW'(MAX_VERTICES);

  // Magnitudes of the accumulators
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = acc_q[i][AW-1] ? AW'(-acc_q[i]) : AW'(acc_q[i]);
    end
  end

  // Newell term operands for the current component
  always_comb begin
    case (cnt_q[1:0])
      2'd0: begin
        t_diff = 17'(ta_q[1]) - 17'(tb_q[1]);
        t_sum  = 17'(tb_q[2]) + 17'(ta_q[2]);
      end
      2'd1: begin
        t_diff = 17'(ta_q[2]) - 17'(tb_q[2]);
        t_sum  = 17'(tb_q[0]) + 17'(ta_q[0]);
      end
      default: begin
        t_diff = 17'(ta_q[0]) - 17'(tb_q[0]);
        t_sum  = 17'(tb_q[1]) + 17'(ta_q[1]);
      end
    endcase
  end

  // Shared multiplier
  always_comb begin
    if (state_q == pnas_pkg::S_DELTA) begin
      mul_a = (cnt_q == CW'(0)) ? cx_q[0] : cx_q[2];
      mul_b = (cnt_q == CW'(0)) ? cx_q[3] : cx_q[1];
    end else begin
      mul_a = t_diff;
      mul_b = t_sum;
    end
    prod = mul_a * mul_b;
  end

  // Square root step
  always_comb begin
    rem_sh = {rem_q, sum_q[SW-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    sq_ge  = rem_sh >= trial;
  end

  // Projection axes from the largest normal component, ties with z to z, a tie of x and y to y
  always_comb begin
    au_c = pnas_pkg::AXIS_X;
    av_c = pnas_pkg::AXIS_Y;
    if (mag[0] > mag[1]) begin
      if (mag[0] > mag[2]) begin
        au_c = pnas_pkg::AXIS_Y;
        av_c = pnas_pkg::AXIS_Z;
      end
    end else if (mag[1] > mag[2]) begin
      au_c = pnas_pkg::AXIS_Z;
      av_c = pnas_pkg::AXIS_X;
    end
  end

  // Divider operands and saturation of its quotient
  always_comb begin
    delta_mag = delta_q[34] ? 35'(-delta_q) : 35'(delta_q);
    cx_mag    = cx_q[k_q][16] ? 17'(-cx_q[k_q]) : 17'(cx_q[k_q]);
    if (state_q == pnas_pkg::S_CDIV) begin
      div_dvd = DW'({cx_mag, 24'd0}) + DW'(delta_mag >> 1);
      div_den = AW'(delta_mag);
      div_neg = cx_q[k_q][16] ^ delta_q[34];
    end else begin
      div_dvd = DW'({mag[k_q], 15'd0}) + DW'(root_q >> 1);
      div_den = root_q;
      div_neg = acc_q[k_q][AW-1];
    end
    if (div_neg) begin
      sat16 = (div_quo > DW'(32768)) ? -16'sd32768 : 16'(-div_quo);
      sat32 = (div_quo > DW'(64'h8000_0000)) ? 32'sh8000_0000 : 32'(-div_quo);
    end else begin
      sat16 = (div_quo > DW'(32767)) ? 16'sd32767 : 16'(div_quo);
      sat32 = (div_quo > DW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(div_quo);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pnas_pkg::S_IDLE: begin
        if (in_acc) begin
          if (room && count_q != '0) begin
            state_d = pnas_pkg::S_TERM;
          end else if (in_data_i.last_vertex) begin
            state_d = (ovf_q || !room) ? pnas_pkg::S_DONE : pnas_pkg::S_TERM;
          end
        end
      end
      pnas_pkg::S_TERM: begin
        if (cnt_q == CW'(3)) begin
          if (closing_q) begin
            state_d = pnas_pkg::S_SQ;
          end else if (!last_q) begin
            state_d = pnas_pkg::S_IDLE;
          end
        end
      end
      pnas_pkg::S_SQ: begin
        if (cnt_q == CW'(AW) && k_q == 2'd2) state_d = pnas_pkg::S_SQRT;
      end
      pnas_pkg::S_SQRT: begin
        if (cnt_q == CW'(AW - 1)) state_d = pnas_pkg::S_NDIV;
      end
      pnas_pkg::S_NDIV: begin
        if (!started_q && root_q == '0) begin
          state_d = pnas_pkg::S_DONE;
        end else if (div_done && k_q == 2'd2) begin
          state_d = (count_q == CNTW'(3)) ? pnas_pkg::S_TRI : pnas_pkg::S_DONE;
        end
      end
      pnas_pkg::S_TRI: state_d = pnas_pkg::S_DELTA;
      pnas_pkg::S_DELTA: begin
        if (cnt_q == CW'(2)) begin
          state_d = pnas_pkg::S_CDIV;
        end else if (cnt_q == CW'(3)) begin
          state_d = pnas_pkg::S_DONE;
        end
      end
      pnas_pkg::S_CDIV: begin
        if (delta_q == '0) begin
          state_d = pnas_pkg::S_DONE;
        end else if (div_done && k_q == 2'd3) begin
          state_d = pnas_pkg::S_DONE;
        end
      end
      pnas_pkg::S_DONE: begin
        if (out_free) state_d = pnas_pkg::S_IDLE;
      end
      default: state_d = pnas_pkg::S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o = (state_q != pnas_pkg::S_IDLE);
    div_start  = !started_q &&
                 ((state_q == pnas_pkg::S_NDIV && root_q != '0) ||
                  (state_q == pnas_pkg::S_CDIV && delta_q != '0));
  end

  pnas_div #(
    .DW(DW),
    .NW(AW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Sequencer control registers and polygon state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pnas_pkg::S_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      started_q   <= 1'b0;
      closing_q   <= 1'b0;
      last_q      <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        first_q[i]  <= '0;
        second_q[i] <= '0;
        prev_q[i]   <= '0;
        acc_q[i]    <= '0;
      end
    end else begin
      state_q <= state_d;
      // Raise valid when a result is loaded, drop it once taken
      if (state_q == pnas_pkg::S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        pnas_pkg::S_IDLE: begin
          if (in_acc) begin
            cnt_q     <= '0;
            last_q    <= in_data_i.last_vertex;
            closing_q <= (count_q == '0);
            if (room) begin
              if (count_q == '0) for (int i = 0; i < 3; i++) first_q[i] <= vin[i];
              if (count_q == CNTW'(1)) for (int i = 0; i < 3; i++) second_q[i] <= vin[i];
              for (int i = 0; i < 3; i++) prev_q[i] <= vin[i];
              count_q <= count_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        pnas_pkg::S_TERM: begin
          // Add each product in the cycle after it is formed
          if (cnt_q != CW'(0)) begin
            acc_q[cnt_q[1:0] - 2'd1] <= acc_q[cnt_q[1:0] - 2'd1] +
                                        {{(AW-34){prod_q[33]}}, prod_q};
          end
          if (cnt_q == CW'(3)) begin
            cnt_q     <= '0;
            k_q       <= '0;
            closing_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        pnas_pkg::S_SQ: begin
          if (cnt_q == CW'(AW)) begin
            cnt_q <= '0;
            k_q   <= k_q + 2'd1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        pnas_pkg::S_SQRT: begin
          cnt_q     <= (cnt_q == CW'(AW - 1)) ? '0 : cnt_q + 1'b1;
          k_q       <= '0;
          started_q <= 1'b0;
        end
        pnas_pkg::S_NDIV: begin
          if (div_start) started_q <= 1'b1;
          if (div_done) begin
            started_q <= 1'b0;
            k_q       <= k_q + 2'd1;
          end
        end
        pnas_pkg::S_TRI: cnt_q <= '0;
        pnas_pkg::S_DELTA: begin
          cnt_q     <= cnt_q + 1'b1;
          k_q       <= '0;
          started_q <= 1'b0;
        end
        pnas_pkg::S_CDIV: begin
          if (div_start) started_q <= 1'b1;
          if (div_done) begin
            started_q <= 1'b0;
            k_q       <= k_q + 2'd1;
          end
        end
        pnas_pkg::S_DONE: begin
          // Hand over the result and clear the polygon
          if (out_free) begin
            count_q     <= '0;
            ovf_q       <= 1'b0;
            for (int i = 0; i < 3; i++) acc_q[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      pnas_pkg::S_IDLE: begin
        if (in_acc) begin
          for (int i = 0; i < 3; i++) begin
            v_q[i]   <= vin[i];
            ta_q[i]  <= (count_q == '0) ? vin[i] : prev_q[i];
            tb_q[i]  <= vin[i];
            nrm_q[i] <= '0;
          end
          for (int i = 0; i < 4; i++) coef_q[i] <= '0;
          area_q   <= '0;
          au_q     <= pnas_pkg::AXIS_X;
          av_q     <= pnas_pkg::AXIS_Y;
          status_q <= (in_data_i.last_vertex && (ovf_q || !room)) ?
                      pnas_pkg::STATUS_OVERFLOW : pnas_pkg::STATUS_OK;
        end
      end
      pnas_pkg::S_TERM: begin
        if (cnt_q != CW'(3)) prod_q <= prod;
        // Set up the closing edge back to the first vertex
        if (cnt_q == CW'(3) && !closing_q) begin
          for (int i = 0; i < 3; i++) begin
            ta_q[i] <= v_q[i];
            tb_q[i] <= first_q[i];
          end
        end
        if (cnt_q == CW'(3)) sum_q <= '0;
      end
      pnas_pkg::S_SQ: begin
        if (cnt_q == CW'(0)) begin
          mcand_q  <= SW'(mag[k_q]);
          mplier_q <= mag[k_q];
        end else begin
          if (mplier_q[0]) sum_q <= sum_q + mcand_q;
          mcand_q  <= {mcand_q[SW-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[AW-1:1]};
        end
        if (cnt_q == CW'(AW) && k_q == 2'd2) begin
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      pnas_pkg::S_SQRT: begin
        rem_q  <= sq_ge ? (AW+2)'(rem_sh - trial) : rem_sh[AW+1:0];
        root_q <= {root_q[AW-2:0], sq_ge};
        sum_q  <= {sum_q[SW-3:0], 2'b00};
      end
      pnas_pkg::S_NDIV: begin
        if (!started_q && root_q == '0) begin
          status_q <= pnas_pkg::STATUS_DEGENERATE;
        end else begin
          area_q <= 41'(root_q >> 1);
        end
        if (div_done) nrm_q[k_q] <= sat16;
      end
      pnas_pkg::S_TRI: begin
        au_q     <= au_c;
        av_q     <= av_c;
        cx_q[0]  <= 17'(second_q[au_c]) - 17'(first_q[au_c]);
        cx_q[1]  <= 17'(first_q[av_c]) - 17'(second_q[av_c]);
        cx_q[2]  <= 17'(first_q[au_c]) - 17'(v_q[au_c]);
        cx_q[3]  <= 17'(v_q[av_c]) - 17'(first_q[av_c]);
      end
      pnas_pkg::S_DELTA: begin
        // Form x1*y2 - x2*y1 over two products
        prod_q <= prod;
        if (cnt_q == CW'(1)) delta_q <= 35'(prod_q);
        if (cnt_q == CW'(2)) delta_q <= delta_q - 35'(prod_q);
      end
      pnas_pkg::S_CDIV: begin
        if (delta_q == '0) begin
          for (int i = 0; i < 4; i++) coef_q[i] <= {{7{cx_q[i][16]}}, cx_q[i], 8'd0};
        end else if (div_done) begin
          coef_q[k_q] <= sat32;
        end
      end
      pnas_pkg::S_DONE: begin
        if (out_free) begin
          out_q.normal_x <= nrm_q[0];
          out_q.normal_y <= nrm_q[1];
          out_q.normal_z <= nrm_q[2];
          out_q.area     <= area_q;
          out_q.axis_u   <= au_q;
          out_q.axis_v   <= av_q;
          out_q.coef_x1  <= coef_q[0];
          out_q.coef_y1  <= coef_q[1];
          out_q.coef_x2  <= coef_q[2];
          out_q.coef_y2  <= coef_q[3];
          out_q.status   <= status_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/pnas_checker.sv */
// Port-level checker for the polygon normal and area setup unit, with its bind.
// Depends on pnas_pkg and polygon_normal_area_setup_unit_macros.svh.
`timescale 1ns / 1ps
`include "polygon_normal_area_setup_unit_macros.svh"

module pnas_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input pnas_pkg::pnas_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pnas_pkg::pnas_out_t out_data_o
);

  logic last_acc;
  logic out_held;
  logic ovf_out;
  logic ovf_clear;
  logic degen_out;
  logic degen_ok;

  // Conditions seen on the ports
  assign last_acc  = in_valid_i && !in_stall_o && in_data_i.last_vertex;
  assign out_held  = out_valid_o && out_stall_i;
  assign ovf_out   = out_valid_o && out_data_o.status == pnas_pkg::STATUS_OVERFLOW;
  assign ovf_clear = out_data_o.area == '0 && out_data_o.normal_x == '0 &&
                     out_data_o.coef_x1 == '0;
  assign degen_out = out_valid_o && out_data_o.status == pnas_pkg::STATUS_DEGENERATE;
  assign degen_ok  = out_data_o.area == '0 && out_data_o.axis_u == pnas_pkg::AXIS_X &&
                     out_data_o.axis_v == pnas_pkg::AXIS_Y;

  // Hold a stalled result item
  `PNAS_ASSERT_NXT(a_out_hold, out_held, out_valid_o && $stable(out_data_o), "stalled result changed")

  // Go busy after the closing vertex
  `PNAS_ASSERT_NXT(a_busy_after_last, last_acc, in_stall_o, "input not stalled after last vertex")

  // Overflow result has zero area, normal_x and coef_x1
  `PNAS_ASSERT_IMP(a_ovf_zero, ovf_out, ovf_clear, "overflow result not cleared")

  // Degenerate normal gives default axes and no area
  `PNAS_ASSERT_IMP(a_degen, degen_out, degen_ok, "degenerate result malformed")

endmodule

bind polygon_normal_area_setup_unit pnas_checker u_pnas_checker (.*);

/* tb/polygon_normal_area_setup_unit_tb.sv */
// Testbench for polygon_normal_area_setup_unit: vertex streams in, one result per polygon out.
// Predicts the normal, area and triangle setup in place; depends on pnas_pkg and the RTL.
`timescale 1ns / 1ps

module polygon_normal_area_setup_unit_tb;

  localparam int MAX_VERTICES = 64;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  pnas_pkg::pnas_in_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  pnas_pkg::pnas_out_t out_data_o;

  polygon_normal_area_setup_unit #(.MAX_VERTICES(MAX_VERTICES)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  // Shadow polygon state
  int                  first_pt[3], second_pt[3], prev_pt[3];
  int                  pt_count;
  longint              newell_sum[3];
  bit                  too_many;
  pnas_pkg::pnas_out_t pending_setups[$];
  bit                  failed = 1'b0;
  int                  sender_idle_pct = 0;
  int                  receiver_idle_pct = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Randomise the result stall at the falling edge
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < receiver_idle_pct);
  end

  function automatic bit [63:0] magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void add_edge(input int a[3], input int b[3]);
    newell_sum[0] += longint'(a[1] - b[1]) * longint'(b[2] + a[2]);
    newell_sum[1] += longint'(a[2] - b[2]) * longint'(b[0] + a[0]);
    newell_sum[2] += longint'(a[0] - b[0]) * longint'(b[1] + a[1]);
  endfunction

  function automatic bit [63:0] sqrt_floor(input bit [127:0] s);
    bit [63:0]  root;
    bit [127:0] rem, trial;
    root = '0;
    rem  = '0;
    for (int i = 63; i >= 0; i--) begin
      rem   = (rem << 2) | s[2*i +: 2];
      trial = ({64'd0, root} << 2) | 128'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Rounded division, halves away from zero, clamped to [lo, hi]
  function automatic longint round_div_clamp(input longint num, input bit [63:0] den,
                                             input longint lo, input longint hi);
    bit [63:0] q;
    q = (magnitude(num) + den / 2) / den;
    if (num < 0) begin
      if (q > magnitude(lo)) return lo;
      return -longint'(q);
    end
    if (q > 64'(hi)) return hi;
    return longint'(q);
  endfunction

  function automatic void clear_polygon();
    pt_count = 0;
    newell_sum = '{0, 0, 0};
    too_many = 1'b0;
  endfunction

  // Advance the shadow state by one vertex; queue a setup on the closing vertex
  function automatic void predict_setup(input pnas_pkg::pnas_in_t it);
    int                  v[3];
    pnas_pkg::pnas_out_t r;
    bit [127:0]          sq;
    bit [63:0]           len, ax, ay, az, m;
    longint              cf[4];
    longint              delta, num;
    int                  au, av;
    v[0] = int'(it.vertex_x);
    v[1] = int'(it.vertex_y);
    v[2] = int'(it.vertex_z);
    if (pt_count >= MAX_VERTICES) begin
      too_many = 1'b1;
    end else begin
      if (pt_count == 0) first_pt = v;
      else add_edge(prev_pt, v);
      if (pt_count == 1) second_pt = v;
      prev_pt = v;
      pt_count++;
    end
    if (!it.last_vertex) return;
    r = '0;
    r.axis_u = pnas_pkg::AXIS_X;
    r.axis_v = pnas_pkg::AXIS_Y;
    r.status = pnas_pkg::STATUS_OK;
    if (too_many) begin
      r.status = pnas_pkg::STATUS_OVERFLOW;
    end else begin
      add_edge(v, first_pt);
      sq = '0;
      for (int k = 0; k < 3; k++) begin
        m  = magnitude(newell_sum[k]);
        sq = sq + {64'd0, m} * {64'd0, m};
      end
      len = sqrt_floor(sq);
      if (len == 0) begin
        r.status = pnas_pkg::STATUS_DEGENERATE;
      end else begin
        r.area     = 41'(len >> 1);
        r.normal_x = 16'(round_div_clamp(newell_sum[0] * 32768, len, -32768, 32767));
        r.normal_y = 16'(round_div_clamp(newell_sum[1] * 32768, len, -32768, 32767));
        r.normal_z = 16'(round_div_clamp(newell_sum[2] * 32768, len, -32768, 32767));
        if (pt_count == 3) begin
          ax = magnitude(newell_sum[0]);
          ay = magnitude(newell_sum[1]);
          az = magnitude(newell_sum[2]);
          au = int'(pnas_pkg::AXIS_X);
          av = int'(pnas_pkg::AXIS_Y);
          if (ax > ay) begin
            if (ax > az) begin
              au = int'(pnas_pkg::AXIS_Y);
              av = int'(pnas_pkg::AXIS_Z);
            end
          end else if (ay > az) begin
            au = int'(pnas_pkg::AXIS_Z);
            av = int'(pnas_pkg::AXIS_X);
          end
          cf[0] = longint'(second_pt[au]) - first_pt[au];
          cf[1] = longint'(first_pt[av]) - second_pt[av];
          cf[2] = longint'(first_pt[au]) - v[au];
          cf[3] = longint'(v[av]) - first_pt[av];
          delta = cf[0] * cf[3] - cf[2] * cf[1];
          for (int k = 0; k < 4; k++) begin
            if (delta == 0) begin
              cf[k] = cf[k] * 256;
            end else begin
              num   = cf[k] * 16777216;
              if (delta < 0) num = -num;
              cf[k] = round_div_clamp(num, magnitude(delta),
                                      longint'(-2147483647) - 1, longint'(2147483647));
            end
          end
          r.axis_u  = 2'(au);
          r.axis_v  = 2'(av);
          r.coef_x1 = 32'(cf[0]);
          r.coef_y1 = 32'(cf[1]);
          r.coef_x2 = 32'(cf[2]);
          r.coef_y2 = 32'(cf[3]);
        end
      end
    end
    pending_setups.push_back(r);
    clear_polygon();
  endfunction

  // Compare each accepted result with the oldest pending setup
  task automatic report_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin
    pnas_pkg::pnas_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_setups.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
        failed = 1'b1;
      end else begin
        e = pending_setups.pop_front();
        report_field("normal_x", longint'(e.normal_x), longint'(out_data_o.normal_x));
        report_field("normal_y", longint'(e.normal_y), longint'(out_data_o.normal_y));
        report_field("normal_z", longint'(e.normal_z), longint'(out_data_o.normal_z));
        report_field("area", longint'(e.area), longint'(out_data_o.area));
        report_field("axis_u", longint'(e.axis_u), longint'(out_data_o.axis_u));
        report_field("axis_v", longint'(e.axis_v), longint'(out_data_o.axis_v));
        report_field("coef_x1", longint'(e.coef_x1), longint'(out_data_o.coef_x1));
        report_field("coef_y1", longint'(e.coef_y1), longint'(out_data_o.coef_y1));
        report_field("coef_x2", longint'(e.coef_x2), longint'(out_data_o.coef_x2));
        report_field("coef_y2", longint'(e.coef_y2), longint'(out_data_o.coef_y2));
        report_field("status", longint'(e.status), longint'(out_data_o.status));
      end
    end
  end

  // Send one vertex item; hold it until accepted
  task automatic send_vertex(input int x, input int y, input int z, input bit last);
    pnas_pkg::pnas_in_t it;
    it.vertex_x = 16'(x);
    it.vertex_y = 16'(y);
    it.vertex_z = 16'(z);
    it.last_vertex = last;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_setup(it);
  endtask

  task automatic send_triangle(input int p[9]);
    for (int i = 0; i < 3; i++) send_vertex(p[3*i], p[3*i+1], p[3*i+2], i == 2);
  endtask

  task automatic test_short_polygons();
    send_vertex(256, -256, 512, 1'b1);
    send_vertex(0, 0, 0, 1'b0);
    send_vertex(768, 256, -128, 1'b1);
  endtask

  task automatic test_axis_choice();
    send_triangle('{0, 0, 0, 256, 0, 0, 0, 256, 0});        // xy plane
    send_triangle('{0, 0, 0, 0, 256, 0, 0, 0, 256});        // yz plane
    send_triangle('{0, 0, 0, 0, 0, 256, 256, 0, 0});        // xz plane
    send_triangle('{0, 0, 0, 256, 0, 0, 0, 256, 256});      // tie y and z
    send_triangle('{256, 0, 0, 0, 256, 0, 0, 0, 256});      // all equal
  endtask

  task automatic test_degenerate_and_extremes();
    send_triangle('{0, 0, 0, 256, 256, 256, 512, 512, 512});  // collinear
    send_triangle('{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768});
    send_triangle('{-32768, -32768, -32768, 32767, -32768, 0, -32768, 32767, 32767});
    for (int i = 0; i < 4; i++) send_vertex(i[0] ? 1000 : -1000, i[1] ? 700 : -700, 5, i == 3);
  endtask

  task automatic test_vertex_limit();
    for (int i = 0; i < MAX_VERTICES; i++)
      send_vertex(i * 300, (i * i) % 4000, -i * 17, i == MAX_VERTICES - 1);
    for (int i = 0; i <= MAX_VERTICES; i++)
      send_vertex(int'($urandom_range(65535)), int'($urandom_range(65535)),
                  int'($urandom_range(65535)), i == MAX_VERTICES);
  endtask

  // Hold off until every pending setup has been returned
  task automatic test_drain_pause();
    send_triangle('{100, 200, 300, -400, 50, 60, 70, -800, 90});
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_setups.size() != 0) @(posedge clk_i);
    send_triangle('{-100, 20, 30, 40, 500, -60, 7, 8, 900});
  endtask

  function automatic int coord(input int shape);
    case (shape)
      0: return int'($urandom_range(65535)) - 32768;
      1: return int'($urandom_range(511)) - 256;
      default: return int'($urandom_range(8191)) - 4096;
    endcase
  endfunction

  task automatic test_random_polygons(input int s_pct, input int r_pct, input int budget);
    int sent, n, shape, roll, zf;
    sender_idle_pct   = s_pct;
    receiver_idle_pct = r_pct;
    sent = 0;
    while (sent < budget) begin
      roll  = $urandom_range(99);
      n     = (roll < 60) ? 3 : (roll < 85) ? $urandom_range(8, 4) :
              (roll < 93) ? $urandom_range(2, 1) : $urandom_range(70, 9);
      shape = $urandom_range(2);
      zf    = coord(shape);
      for (int i = 0; i < n; i++) begin
        // Mostly near-planar polygons, some noise in full 3D
        send_vertex(coord(shape), coord(shape), (roll % 3 == 0) ? coord(shape) : zf + i,
                    i == n - 1);
      end
      sent += n;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_short_polygons();
    test_axis_choice();
    test_degenerate_and_extremes();
    test_vertex_limit();
    test_drain_pause();
    test_random_polygons(34, 49, 210);
    test_random_polygons(49, 34, 210);
    test_random_polygons(0, 0, 210);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_setups.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
